### hw/rtl/coarse_to_fine_sequence_alignment_top_defines.svh
// Assertion macros used by the alignment block checker.
`ifndef COARSE_TO_FINE_SEQUENCE_ALIGNMENT_TOP_DEFINES_SVH
`define COARSE_TO_FINE_SEQUENCE_ALIGNMENT_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define C2FSA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define C2FSA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/c2fsa_pkg.sv
// Shared types and constants of the coarse-to-fine alignment block.
`timescale 1ns / 1ps
package c2fsa_pkg;

  // Operation codes carried in tuser of the input channel
  typedef enum logic [1:0] {
    OP_FIRST  = 2'd0,
    OP_SECOND = 2'd1,
    OP_SEARCH = 2'd2
  } op_t;

  localparam int OP_W       = 2;
  localparam int SUM_PORT_W = 32;
  localparam int SHIFT_W    = 14;
  localparam int STEP_W     = 16;
  localparam int STEP_RESET = 100;

  // x / 10 for 16-bit x: (x * 0xCCCD) >> 19
  localparam logic [15:0] DIV10_MUL   = 16'hCCCD;
  localparam int          DIV10_SHIFT = 19;

endpackage

### hw/rtl/coarse_to_fine_sequence_alignment_top.sv
// Coarse-to-fine shift search between two stored sequences of RGB frame sums.
`timescale 1ns / 1ps
// Frame items (operation first/second) are written one per cycle, while the
// block is idle, into two single-port-read frame memories; an append beyond
// MAX_FRAMES is dropped. A search item stalls the input until its result is
// registered: every tested shift walks its overlap through both memories at
// one frame per cycle, then a coarse pass compares the cross-multiplied mean
// with two registered multiplies and a compare, while the final pass forms
// the truncated mean of the SUMW-bit sum with a bit-serial divider
// (SUMW = min(SAMPLE_BITS,32) + 2 + clog2(MAX_FRAMES+1)). A shift with no
// overlap skips the walk. The memory walk dominates the search time. Both
// frame counts are cleared when the search ends.
module coarse_to_fine_sequence_alignment_top #(
  parameter int MAX_FRAMES  = 4096,
  parameter int SAMPLE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // red_sum[31:0], green_sum[63:32], blue_sum[95:64]
  input  logic [1:0]  in_tuser,   // operation[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // best_shift[13:0], zero pad [15:14]
  output logic        out_tuser,  // found[0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data    // coarse_step
);

  localparam int CW   = $clog2(MAX_FRAMES + 1);
  localparam int AW   = $clog2(MAX_FRAMES);
  localparam int DW   = (SAMPLE_BITS < 32) ? SAMPLE_BITS : 32;
  localparam int SW   = ((CW > 16) ? CW : 16) + 2;
  localparam int SUMW = DW + 2 + CW;
  localparam int PW   = SUMW + CW;
  localparam int DCW  = $clog2(SUMW + 1);
  localparam int FW   = 3 * DW;
  localparam int SH_W = c2fsa_pkg::SHIFT_W;
  localparam int ST_W = c2fsa_pkg::STEP_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PASS, ST_SETUP, ST_WALK, ST_MUL_A, ST_MUL_B,
    ST_CMP, ST_DIV, ST_NEXT, ST_WINDOW, ST_DONE
  } state_t;

  state_t state_r;

  logic [CW-1:0]          n1_r, n2_r;
  logic [ST_W-1:0]        cfg_step_r, step_r;
  logic signed [SW-1:0]   lo_r, hi_r, i_r, best_r;
  logic                   have_r, found_r;
  logic [CW-1:0]          len_r, k_r, bl_r;
  logic [AW-1:0]          a_r, b_r;
  logic                   rvld_r, dvld_r;
  logic [DW+1:0]          d_r;
  logic [SUMW-1:0]        acc_r, bs_r, bq_r, div_q_r;
  logic [CW-1:0]          div_rem_r;
  logic [DCW-1:0]         div_cnt_r;
  logic [PW-1:0]          prod_a_r, prod_b_r;
  logic                   out_valid_r, out_found_r;
  logic [SH_W-1:0]        out_shift_r;

  // Frame memories, one frame (three sums) per entry
  logic [FW-1:0] mem_a [MAX_FRAMES];
  logic [FW-1:0] mem_b [MAX_FRAMES];
  logic [FW-1:0] rd_a_r, rd_b_r;

  logic          acc_in;
  c2fsa_pkg::op_t in_op;
  logic          wr_a, wr_b;
  logic [FW-1:0] wdata;
  logic [AW-1:0] raddr_a, raddr_b;

  assign in_tready = (state_r == ST_IDLE);
  assign acc_in    = in_tvalid && in_tready;
  assign in_op     = c2fsa_pkg::op_t'(in_tuser);
  assign cfg_ready = 1'b1;
  assign wdata     = {in_tdata[64 +: DW], in_tdata[32 +: DW], in_tdata[0 +: DW]};
  assign wr_a      = acc_in && (in_op == c2fsa_pkg::OP_FIRST)
                     && (n1_r < CW'(MAX_FRAMES));
  assign wr_b      = acc_in && (in_op == c2fsa_pkg::OP_SECOND)
                     && (n2_r < CW'(MAX_FRAMES));
  assign raddr_a   = a_r + k_r[AW-1:0];
  assign raddr_b   = b_r + k_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (wr_a) begin
      mem_a[n1_r[AW-1:0]] <= wdata;
    end
    rd_a_r <= mem_a[raddr_a];
  end

  always_ff @(posedge clk) begin
    if (wr_b) begin
      mem_b[n2_r[AW-1:0]] <= wdata;
    end
    rd_b_r <= mem_b[raddr_b];
  end

  // Per-frame absolute difference of the three channels
  logic [DW-1:0] ad0, ad1, ad2;
  logic [DW+1:0] d_nxt;
  always_comb begin
    ad0 = (rd_a_r[0 +: DW] > rd_b_r[0 +: DW]) ? rd_a_r[0 +: DW] - rd_b_r[0 +: DW]
                                              : rd_b_r[0 +: DW] - rd_a_r[0 +: DW];
    ad1 = (rd_a_r[DW +: DW] > rd_b_r[DW +: DW]) ? rd_a_r[DW +: DW] - rd_b_r[DW +: DW]
                                                : rd_b_r[DW +: DW] - rd_a_r[DW +: DW];
    ad2 = (rd_a_r[2*DW +: DW] > rd_b_r[2*DW +: DW])
          ? rd_a_r[2*DW +: DW] - rd_b_r[2*DW +: DW]
          : rd_b_r[2*DW +: DW] - rd_a_r[2*DW +: DW];
    d_nxt = (DW+2)'(ad0) + (DW+2)'(ad1) + (DW+2)'(ad2);
  end

  // Overlap of the current shift: length and start addresses
  logic signed [SW-1:0] n1s, n2s, ov_x, ov_y, len_s, a_s, b_s;
  always_comb begin
    n1s = SW'(n1_r);
    n2s = SW'(n2_r);
    if (i_r > 0) begin
      ov_x = n1s - i_r;
      ov_y = n2s;
      a_s  = i_r;
      b_s  = '0;
    end else begin
      ov_x = n2s + i_r;
      ov_y = n1s;
      a_s  = '0;
      b_s  = -i_r;
    end
    len_s = (ov_y < ov_x) ? ov_y : ov_x;
  end

  // Window update terms and step / 10
  logic signed [SW-1:0] step_s, best_m, best_p;
  logic [ST_W+15:0]     div10_prod;
  logic [ST_W-1:0]      step_div10;
  always_comb begin
    step_s     = SW'(step_r);
    best_m     = best_r - step_s;
    best_p     = best_r + step_s;
    div10_prod = step_r * c2fsa_pkg::DIV10_MUL;
    step_div10 = ST_W'(div10_prod >> c2fsa_pkg::DIV10_SHIFT);
  end

  // Divider step
  logic [CW:0]   div_sh;
  logic          div_bit;
  logic [CW-1:0] div_rem_nxt;
  always_comb begin
    div_sh      = {div_rem_r, div_q_r[SUMW-1]};
    div_bit     = (div_sh >= {1'b0, len_r});
    div_rem_nxt = div_bit ? CW'(div_sh - {1'b0, len_r}) : div_sh[CW-1:0];
  end

  // Control, search datapath and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      n1_r        <= '0;
      n2_r        <= '0;
      cfg_step_r  <= ST_W'(c2fsa_pkg::STEP_RESET);
      rvld_r      <= 1'b0;
      dvld_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cfg_step_r <= cfg_data;
      end
      // the done state reloads the output register itself
      if (out_valid_r && out_tready && state_r != ST_DONE) begin
        out_valid_r <= 1'b0;
      end

      // read and accumulate pipeline of the overlap walk
      rvld_r <= (state_r == ST_WALK) && (k_r < len_r);
      dvld_r <= rvld_r;
      d_r    <= d_nxt;
      if (dvld_r) begin
        acc_r <= acc_r + SUMW'(d_r);
      end

      case (state_r)
        ST_IDLE: begin
          if (wr_a) begin
            n1_r <= n1_r + 1'b1;
          end
          if (wr_b) begin
            n2_r <= n2_r + 1'b1;
          end
          if (acc_in && in_op == c2fsa_pkg::OP_SEARCH) begin
            lo_r    <= -SW'(n2_r);
            hi_r    <= SW'(n1_r);
            step_r  <= cfg_step_r;
            found_r <= 1'b0;
            state_r <= ST_PASS;
          end
        end
        ST_PASS: begin
          best_r  <= lo_r;
          i_r     <= lo_r;
          have_r  <= 1'b0;
          bs_r    <= '0;
          bl_r    <= CW'(1);
          bq_r    <= '0;
          state_r <= ST_SETUP;
        end
        ST_SETUP: begin
          if (i_r >= hi_r) begin
            state_r <= ST_WINDOW;
          end else if (len_s <= 0) begin
            state_r <= ST_NEXT;
          end else begin
            len_r   <= len_s[CW-1:0];
            a_r     <= a_s[AW-1:0];
            b_r     <= b_s[AW-1:0];
            k_r     <= '0;
            acc_r   <= '0;
            state_r <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (k_r < len_r) begin
            k_r <= k_r + 1'b1;
          end else if (!rvld_r && !dvld_r) begin
            if (step_r == '0) begin
              div_q_r   <= acc_r;
              div_rem_r <= '0;
              div_cnt_r <= '0;
              state_r   <= ST_DIV;
            end else begin
              state_r <= ST_MUL_A;
            end
          end
        end
        ST_MUL_A: begin
          prod_a_r <= PW'(acc_r) * PW'(bl_r);
          state_r  <= ST_MUL_B;
        end
        ST_MUL_B: begin
          prod_b_r <= PW'(bs_r) * PW'(len_r);
          state_r  <= ST_CMP;
        end
        ST_CMP: begin
          found_r <= 1'b1;
          if (!have_r || prod_a_r < prod_b_r) begin
            have_r <= 1'b1;
            bs_r   <= acc_r;
            bl_r   <= len_r;
            best_r <= i_r;
          end
          state_r <= ST_NEXT;
        end
        ST_DIV: begin
          if (div_cnt_r == DCW'(SUMW)) begin
            found_r <= 1'b1;
            if (!have_r || div_q_r < bq_r) begin
              have_r <= 1'b1;
              bq_r   <= div_q_r;
              best_r <= i_r;
            end
            state_r <= ST_NEXT;
          end else begin
            div_rem_r <= div_rem_nxt;
            div_q_r   <= {div_q_r[SUMW-2:0], div_bit};
            div_cnt_r <= div_cnt_r + 1'b1;
          end
        end
        ST_NEXT: begin
          i_r     <= i_r + ((step_r == '0) ? SW'(1) : step_s);
          state_r <= ST_SETUP;
        end
        ST_WINDOW: begin
          if (step_r == '0) begin
            state_r <= ST_DONE;
          end else begin
            if (best_m > lo_r) begin
              lo_r <= best_m;
            end
            if (best_p < hi_r) begin
              hi_r <= best_p;
            end
            step_r  <= step_div10;
            state_r <= ST_PASS;
          end
        end
        ST_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_shift_r <= best_r[SH_W-1:0];
            out_found_r <= found_r;
            n1_r        <= '0;
            n2_r        <= '0;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_shift_r};
  assign out_tuser  = out_found_r;

endmodule

### hw/rtl/c2fsa_checker.sv
// Port-level checker of the alignment block, bound to its top level.
`timescale 1ns / 1ps
`include "coarse_to_fine_sequence_alignment_top_defines.svh"
module c2fsa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tuser
);

  // stalled result holds
  `C2FSA_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")

  // a search item blocks the input on the next cycle
  `C2FSA_ASSERT_NXT(a_search_busy,
    in_tvalid && in_tready && in_tuser == c2fsa_pkg::OP_SEARCH, !in_tready,
    "input not stalled after search item")

  // a new result only comes out of a busy search
  `C2FSA_ASSERT_IMP(a_result_src, $rose(out_tvalid), !$past(in_tready),
    "result without a running search")

  // padding bits of the result stay zero
  `C2FSA_ASSERT_IMP(a_out_pad, out_tvalid, out_tdata[15:14] == 2'b00, "result padding not zero")

endmodule

bind coarse_to_fine_sequence_alignment_top c2fsa_checker u_c2fsa_checker (.*);
